// ===== rtl/nmea_pkg.sv =====
// Shared constants, types and helpers for the NMEA sentence framer.
// Depends on nothing; imported by nmea_sentence_framer_top and its testbench.
package nmea_pkg;

    // Framing limits
    localparam int unsigned MSG_LEN    = 128;
    localparam int unsigned MAX_DELIMS = 32;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] phase_t;
    typedef logic [2:0] kind_t;

    // Framer phases
    localparam phase_t PH_WAIT = 3'd0;
    localparam phase_t PH_DATA = 3'd1;
    localparam phase_t PH_SUM1 = 3'd2;
    localparam phase_t PH_SUM2 = 3'd3;
    localparam phase_t PH_CR   = 3'd4;
    localparam phase_t PH_LF   = 3'd5;

    // Sentence kinds
    localparam kind_t KIND_NONE    = 3'd0;
    localparam kind_t KIND_GGA     = 3'd1;
    localparam kind_t KIND_RMC     = 3'd2;
    localparam kind_t KIND_GLGSV   = 3'd3;
    localparam kind_t KIND_GPGSV   = 3'd4;
    localparam kind_t KIND_UNKNOWN = 3'd5;

    // Register byte addresses
    localparam logic [1:0] ADDR_MIN_LENGTH = 2'd0;
    localparam byte_t      MIN_LENGTH_RST  = 8'd12;

    // Characters
    localparam byte_t CH_DOLLAR = 8'h24;
    localparam byte_t CH_COMMA  = 8'h2C;
    localparam byte_t CH_STAR   = 8'h2A;
    localparam byte_t CH_CR     = 8'h0D;
    localparam byte_t CH_LF     = 8'h0A;
    localparam byte_t CH_LOW    = 8'h20;
    localparam byte_t CH_HIGH   = 8'h7E;

    // Names, first character in the lowest byte
    localparam logic [39:0] NAME_GPGGA = 40'h41_47_47_50_47;
    localparam logic [39:0] NAME_GNGGA = 40'h41_47_47_4E_47;
    localparam logic [39:0] NAME_GPRMC = 40'h43_4D_52_50_47;
    localparam logic [39:0] NAME_GNRMC = 40'h43_4D_52_4E_47;
    localparam logic [39:0] NAME_GLGSV = 40'h56_53_47_4C_47;
    localparam logic [39:0] NAME_GPGSV = 40'h56_53_47_50_47;

    // Hex digit value; anything that is not A-F or a-f wraps as b - '0'
    function automatic byte_t hex_value(input byte_t b);
        byte_t v;
        if (b >= 8'h41 && b <= 8'h46)
        begin
            v = b - 8'h37;
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            v = b - 8'h57;
        end
        else
        begin
            v = b - 8'h30;
        end
        return v;
    endfunction

    function automatic kind_t kind_of_name(input logic [39:0] name);
        kind_t k;
        if (name == NAME_GNGGA || name == NAME_GPGGA)
        begin
            k = KIND_GGA;
        end
        else if (name == NAME_GNRMC || name == NAME_GPRMC)
        begin
            k = KIND_RMC;
        end
        else if (name == NAME_GLGSV)
        begin
            k = KIND_GLGSV;
        end
        else if (name == NAME_GPGSV)
        begin
            k = KIND_GPGSV;
        end
        else
        begin
            k = KIND_UNKNOWN;
        end
        return k;
    endfunction

endpackage

// ===== rtl/nmea_sentence_framer_top.sv =====
// NMEA 0183 sentence framer: one received byte in, one result out per item.
// Depends on nmea_pkg.
//
// Takes one byte per clock cycle while the result side is not stalled. Each item
// passes an input register, the framing logic and a result register, and its
// result is offered from the result register; both registers are held under
// back-pressure and the next byte is taken while a result still waits. Every
// byte gives exactly one result: all zero except on the LF that closes a
// sentence of at least min_length bytes with a matching checksum. min_length
// (reset 12) sits at byte address 0 of the APB port and should be written only
// when no item is in flight. There is no clearing pass after reset.
module nmea_sentence_framer_top
    import nmea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] delimiter_count, [13:6] sentence_length, 0 above
    output logic [2:0]  m_tuser,   // [2:0] sentence_kind
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration
    byte_t       min_length_reg;

    // input register
    logic        in_valid_reg;
    byte_t       in_byte_reg;

    // framing state
    phase_t      phase_reg,      phase_next;
    byte_t       byte_count_reg, byte_count_next;
    logic [5:0]  delim_reg,      delim_next;
    byte_t       xor_reg,        xor_next;
    logic [39:0] name_reg,       name_next;
    byte_t       rsum_reg,       rsum_next;

    // result register
    logic        out_valid_reg;
    kind_t       out_kind_reg,   out_kind_next;
    logic [5:0]  out_delim_reg,  out_delim_next;
    byte_t       out_len_reg,    out_len_next;

    logic        advance;
    logic        abort;
    byte_t       b;
    byte_t       len_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_len_reg, out_delim_reg};

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_LENGTH) ? {24'd0, min_length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LENGTH_RST;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_MIN_LENGTH)
        begin
            min_length_reg <= pwdata[7:0];
        end
    end

    // Framing logic
    always_comb
    begin
        b = in_byte_reg;
        abort = (phase_reg != PH_WAIT &&
                 (delim_reg >= 6'(MAX_DELIMS) || byte_count_reg >= 8'(MSG_LEN))) ||
                (b != CH_CR && b != CH_LF && (b < CH_LOW || b > CH_HIGH));

        // an abort clears the frame before the byte is looked at
        phase_next      = abort ? PH_WAIT : phase_reg;
        byte_count_next = abort ? 8'd0    : byte_count_reg;
        delim_next      = abort ? 6'd0    : delim_reg;
        xor_next        = abort ? 8'd0    : xor_reg;
        name_next       = abort ? 40'd0   : name_reg;
        rsum_next       = abort ? 8'd0    : rsum_reg;

        out_kind_next  = KIND_NONE;
        out_delim_next = 6'd0;
        out_len_next   = 8'd0;
        len_inc        = byte_count_next + 8'd1;

        unique case (phase_next)
            PH_WAIT:
            begin
                if (b == CH_DOLLAR)
                begin
                    byte_count_next = 8'd1;
                    phase_next      = PH_DATA;
                end
            end
            PH_DATA:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    if (byte_count_next == 8'(i + 1))
                    begin
                        name_next[8*i +: 8] = name_next[8*i +: 8] | b;
                    end
                end
                if (b == CH_COMMA || b == CH_STAR)
                begin
                    delim_next = delim_next + 6'd1;
                end
                if (b != CH_STAR)
                begin
                    xor_next = xor_next ^ b;
                end
                if (len_inc >= 8'(MSG_LEN - 4))
                begin
                    // buffer overflow, star included
                    phase_next      = PH_WAIT;
                    byte_count_next = 8'd0;
                    delim_next      = 6'd0;
                    xor_next        = 8'd0;
                    name_next       = 40'd0;
                    rsum_next       = 8'd0;
                end
                else
                begin
                    byte_count_next = len_inc;
                    if (b == CH_STAR)
                    begin
                        phase_next = PH_SUM1;
                    end
                end
            end
            PH_SUM1:
            begin
                rsum_next       = hex_value(b) << 4;
                byte_count_next = len_inc;
                phase_next      = PH_SUM2;
            end
            PH_SUM2:
            begin
                rsum_next       = rsum_next | hex_value(b);
                byte_count_next = len_inc;
                phase_next      = PH_CR;
            end
            PH_CR:
            begin
                if (b == CH_CR)
                begin
                    byte_count_next = len_inc;
                    phase_next      = PH_LF;
                end
                else
                begin
                    phase_next      = PH_WAIT;
                    byte_count_next = 8'd0;
                    delim_next      = 6'd0;
                    xor_next        = 8'd0;
                    name_next       = 40'd0;
                    rsum_next       = 8'd0;
                end
            end
            PH_LF:
            begin
                if (b == CH_LF && len_inc >= min_length_reg && xor_next == rsum_next)
                begin
                    out_kind_next  = kind_of_name(name_next);
                    out_delim_next = delim_next;
                    out_len_next   = len_inc;
                end
                phase_next      = PH_WAIT;
                byte_count_next = 8'd0;
                delim_next      = 6'd0;
                xor_next        = 8'd0;
                name_next       = 40'd0;
                rsum_next       = 8'd0;
            end
            default:
            begin
                phase_next      = PH_WAIT;
                byte_count_next = 8'd0;
                delim_next      = 6'd0;
                xor_next        = 8'd0;
                name_next       = 40'd0;
                rsum_next       = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_WAIT;
            byte_count_reg <= 8'd0;
            delim_reg      <= 6'd0;
            xor_reg        <= 8'd0;
            name_reg       <= 40'd0;
            rsum_reg       <= 8'd0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                phase_reg      <= phase_next;
                byte_count_reg <= byte_count_next;
                delim_reg      <= delim_next;
                xor_reg        <= xor_next;
                name_reg       <= name_next;
                rsum_reg       <= rsum_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_kind_reg  <= out_kind_next;
            out_delim_reg <= out_delim_next;
            out_len_reg   <= out_len_next;
        end
    end

    // Assertions
    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_NONE) |-> (m_tdata == 16'd0))
        else $error("invalid result carries payload");

    a_valid_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_NONE) |->
        (m_tdata[13:6] >= 8'd6 && m_tdata[5:0] != 6'd0))
        else $error("valid sentence too short or without star");

    a_wait_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT) |->
        (byte_count_reg == 8'd0 && delim_reg == 6'd0 && xor_reg == 8'd0))
        else $error("frame state not cleared while waiting");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg < 8'(MSG_LEN))
        else $error("byte count beyond buffer");

endmodule

// ===== tb/nmea_sentence_framer_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nmea_sentence_framer_top: NMEA byte streams in, framed results out.
// Depends on nmea_pkg and the framer RTL; holds its own byte-level framing predictor.
module nmea_sentence_framer_top_tb;
    import nmea_pkg::*;

    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 8;
    // a common name that the block must report as unknown
    localparam logic [39:0] NAME_GPGSA = 40'h41_53_47_50_47;

    typedef struct packed {
        kind_t      kind;
        logic [5:0] delims;
        logic [7:0] length;
    } frame_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [5:0] delimiter_count, [13:6] sentence_length
    logic [2:0]  m_tuser;           // [2:0] sentence_kind
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = 2'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // framer predictor state
    phase_t      fr_phase = PH_WAIT;
    int          fr_count = 0;
    logic [5:0]  fr_delims = '0;
    byte_t       fr_xor = '0;
    logic [39:0] fr_name = '0;
    byte_t       fr_sum = '0;
    byte_t       cfg_min_len = MIN_LENGTH_RST;

    byte_t       rx_bytes_q[$];
    frame_out_t  frame_out_q[$];
    frame_out_t  want;

    int pushed_total = 0;
    int taken_total = 0;
    int fail_count = 0;
    int in_stall_cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int kind_seen [0:7] = '{default: 0};
    bit item_taken = 1'b0;
    bit hold_go = 1'b0;
    bit rx_hold = 1'b0;

    nmea_sentence_framer_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void drop_frame();
        fr_phase  = PH_WAIT;
        fr_count  = 0;
        fr_delims = '0;
        fr_xor    = '0;
        fr_name   = '0;
        fr_sum    = '0;
    endfunction

    // checksum digit; non-hex characters wrap as b - '0'
    function automatic byte_t digit_val(input byte_t b);
        if (b inside {[8'h41:8'h46]})
            return b - 8'h41 + 8'd10;
        if (b inside {[8'h61:8'h66]})
            return b - 8'h61 + 8'd10;
        return b - 8'h30;
    endfunction

    function automatic kind_t name_kind(input logic [39:0] n);
        case (n)
            NAME_GPGGA, NAME_GNGGA: return KIND_GGA;
            NAME_GPRMC, NAME_GNRMC: return KIND_RMC;
            NAME_GLGSV:             return KIND_GLGSV;
            NAME_GPGSV:             return KIND_GPGSV;
            default:                return KIND_UNKNOWN;
        endcase
    endfunction

    function automatic frame_out_t frame_byte(input byte_t b);
        frame_out_t r;
        r = '0;
        if (fr_phase != PH_WAIT && (fr_delims >= MAX_DELIMS || fr_count >= MSG_LEN))
            drop_frame();
        if (b != CH_CR && b != CH_LF && (b < CH_LOW || b > CH_HIGH))
            drop_frame();
        case (fr_phase)
            PH_WAIT:
            begin
                if (b == CH_DOLLAR)
                begin
                    drop_frame();
                    fr_count = 1;
                    fr_phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (fr_count >= 1 && fr_count <= 5)
                    fr_name[8*(fr_count-1) +: 8] = b;
                if (b == CH_COMMA || b == CH_STAR)
                    fr_delims = fr_delims + 6'd1;
                if (b != CH_STAR)
                    fr_xor = fr_xor ^ b;
                fr_count++;
                // overflow wins even over the star
                if (fr_count >= MSG_LEN - 4)
                    drop_frame();
                else if (b == CH_STAR)
                    fr_phase = PH_SUM1;
            end
            PH_SUM1:
            begin
                fr_sum = digit_val(b) << 4;
                fr_count++;
                fr_phase = PH_SUM2;
            end
            PH_SUM2:
            begin
                fr_sum = fr_sum | digit_val(b);
                fr_count++;
                fr_phase = PH_CR;
            end
            PH_CR:
            begin
                if (b == CH_CR)
                begin
                    fr_count++;
                    fr_phase = PH_LF;
                end
                else
                    drop_frame();
            end
            PH_LF:
            begin
                if (b == CH_LF)
                begin
                    fr_count++;
                    if (fr_count >= cfg_min_len && fr_xor == fr_sum)
                    begin
                        r.kind   = name_kind(fr_name);
                        r.delims = fr_delims;
                        r.length = fr_count[7:0];
                    end
                end
                drop_frame();
            end
            default: drop_frame();
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- driver and monitor

    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || item_taken)
        begin
            if (rx_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tdata  <= rx_bytes_q.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
        item_taken = 1'b0;
    end

    always @(negedge clk)
    begin
        if (!rst_n || rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // long receiver hold-off, counted here
    always
    begin
        @(posedge hold_go);
        rx_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold = 1'b0;
    end

    task automatic check_field(input string what, input logic [7:0] exp_v, input logic [7:0] got);
        if (got !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                frame_out_q.push_back(frame_byte(s_tdata));
                taken_total++;
                item_taken = 1'b1;
            end
            if (s_tvalid && !s_tready)
                in_stall_cycles++;
            if (m_tvalid && m_tready)
            begin
                if (frame_out_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got kind %0d tdata %h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = frame_out_q.pop_front();
                    check_field("sentence_kind", 8'(want.kind), 8'(m_tuser));
                    check_field("delimiter_count", 8'(want.delims), 8'(m_tdata[5:0]));
                    check_field("sentence_length", want.length, m_tdata[13:6]);
                    check_field("tdata padding", 8'd0, 8'(m_tdata[15:14]));
                    kind_seen[want.kind]++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void push_byte(input byte_t b);
        rx_bytes_q.push_back(b);
        pushed_total++;
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic byte_t text_xor(input string s);
        byte_t x;
        x = '0;
        for (int i = 0; i < s.len(); i++)
            x ^= s[i];
        return x;
    endfunction

    function automatic byte_t hex_char(input logic [3:0] n, input bit lower);
        if (n < 10)
            return 8'h30 + n;
        return (lower ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    // printable, never a star; now and then a dollar, CR or LF
    function automatic byte_t body_char();
        byte_t c;
        case ($urandom_range(0, 39))
            0:       c = CH_DOLLAR;
            1:       c = CH_CR;
            2:       c = CH_LF;
            default:
            begin
                c = byte_t'($urandom_range(CH_LOW, CH_HIGH));
                if (c == CH_STAR)
                    c = CH_COMMA;
            end
        endcase
        return c;
    endfunction

    task automatic queue_sentence();
        byte_t       line[$];
        logic [39:0] name;
        byte_t       csum, bad;
        int          shape, nfields, flen, nname, pick;
        shape = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       name = NAME_GPGGA;
            1:       name = NAME_GNGGA;
            2:       name = NAME_GPRMC;
            3:       name = NAME_GNRMC;
            4:       name = NAME_GLGSV;
            5:       name = NAME_GPGSV;
            6:       name = NAME_GPGSA;
            default:
            begin
                for (int i = 0; i < 5; i++)
                    name[8*i +: 8] = body_char();
            end
        endcase
        nname = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 4) : 5;
        line.push_back(CH_DOLLAR);
        for (int i = 0; i < nname; i++)
            line.push_back(name[8*i +: 8]);
        // mostly short sentences; a few overflow the delimiters or the buffer
        if (shape < 94)
            nfields = $urandom_range(0, 8);
        else if (shape < 97)
            nfields = $urandom_range(30, 36);
        else
            nfields = 2;
        for (int f = 0; f < nfields; f++)
        begin
            line.push_back(CH_COMMA);
            if (shape < 94)
                flen = $urandom_range(0, 6);
            else if (shape < 97)
                flen = $urandom_range(0, 1);
            else
                flen = $urandom_range(56, 62);
            for (int j = 0; j < flen; j++)
                line.push_back(body_char());
        end
        csum = '0;
        for (int i = 1; i < line.size(); i++)
            csum ^= line[i];
        line.push_back(CH_STAR);
        pick = $urandom_range(0, 99);
        if (pick >= 80 && pick < 90)
            csum ^= byte_t'($urandom_range(1, 255));
        if (pick < 90)
        begin
            line.push_back(hex_char(csum[7:4], pick >= 70 && pick < 80));
            line.push_back(hex_char(csum[3:0], pick >= 70 && pick < 80));
        end
        else
        begin
            line.push_back(body_char());
            line.push_back(body_char());
        end
        pick = $urandom_range(0, 99);
        if (pick < 90)
        begin
            line.push_back(CH_CR);
            line.push_back(CH_LF);
        end
        else if (pick < 94)
            line.push_back(CH_LF);
        else
        begin
            line.push_back(CH_CR);
            line.push_back(body_char());
        end
        if ($urandom_range(0, 19) == 0)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                bad = byte_t'($urandom_range(0, 8'h1F));
                if (bad == CH_CR || bad == CH_LF)
                    bad = 8'h00;
            end
            else
                bad = byte_t'($urandom_range(8'h7F, 8'hFF));
            line.insert($urandom_range(1, line.size() - 1), bad);
        end
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3)) push_byte(byte_t'($urandom_range(0, 255)));
        foreach (line[i])
            push_byte(line[i]);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (taken_total != pushed_total || frame_out_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int rx_pct, input int nbytes,
                             input bit long_hold);
        int target;
        @(posedge clk);
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
        target        = pushed_total + nbytes;
        while (pushed_total < target)
            queue_sentence();
        if (long_hold)
            hold_go = 1'b1;
        wait_drained();
        hold_go = 1'b0;
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = ADDR_MIN_LENGTH;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_min_length();
        logic [31:0] rd;
        apb_access(1'b0, 32'd0, rd);
        if (rd[7:0] !== cfg_min_len)
        begin
            $display("%0t: min_length readback mismatch, expected %0d, got %0d",
                     $time, cfg_min_len, rd[7:0]);
            fail_count++;
        end
    endtask

    task automatic set_min_length(input byte_t v);
        logic [31:0] wd, rd;
        // upper bits are junk; only the low byte is the register
        wd       = $urandom();
        wd[7:0]  = v;
        apb_access(1'b1, wd, rd);
        cfg_min_len = v;
        check_min_length();
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        check_min_length();

        // directed: byte extremes while idle, a valid GGA of exactly the minimum
        // length, an abort on a non-printable byte, a short sentence with a non-hex sum
        @(posedge clk);
        push_byte(8'h00);
        push_byte(8'hFF);
        queue_text($sformatf("$GPGGA,*%02X\015\n", text_xor("GPGGA,")));
        queue_text("$A");
        push_byte(8'h7F);
        queue_text("$*ZZ\015\n");
        wait_drained();

        run_phase(0, 0, 250, 1'b0);
        set_min_length(8'd0);
        run_phase(63, 0, 250, 1'b0);
        set_min_length(8'hFF);
        run_phase(0, 63, 200, 1'b0);
        set_min_length(byte_t'($urandom_range(13, 40)));
        run_phase(9, 9, 250, 1'b0);
        // receiver held off while bytes keep coming
        set_min_length(8'd1);
        run_phase(0, 0, 150, 1'b1);
        set_min_length(MIN_LENGTH_RST);
        run_phase(9, 9, 130, 1'b0);

        $display("%0d bytes framed; valid sentences: GGA %0d, RMC %0d, GLGSV %0d,",
                 taken_total, kind_seen[KIND_GGA], kind_seen[KIND_RMC],
                 kind_seen[KIND_GLGSV]);
        $display("GPGSV %0d, other %0d; min_length swept over 12, 0, 255, random and 1;",
                 kind_seen[KIND_GPGSV], kind_seen[KIND_UNKNOWN]);
        $display("input stalled for %0d cycles", in_stall_cycles);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
